/* src/pidc_pkg.sv */
// Package for the PID controller: microcode types, control word ROM and fixed-point constants.
package pidc_pkg;

	// Integral state width and the split point used for the integral term.
	localparam int INT_W  = 48;
	localparam int INT_LO = 24;
	// Low part of the derivative that is multiplied separately.
	localparam int DL_W   = 26;
	// Accumulator width for the effort sum at 2^-22 effort.
	localparam int SUM_W  = 64;
	// Width of the second multiplier operand.
	localparam int MB_W   = 27;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_RATE      = 3'd5;
	localparam int CFG_DATA_W = 47;

	// Reset values of the period and rate registers.
	localparam logic [23:0] STEP_PERIOD_RST = 24'd167772;
	localparam logic [15:0] LOOP_RATE_RST   = 16'd100;

	// Saturation and rounding constants.
	localparam logic signed [SUM_W-1:0] SUM_SAT   = 64'sd4194304;
	localparam logic signed [SUM_W-1:0] HI_SAT    = 64'sd17179869184;
	localparam logic signed [SUM_W-1:0] RND_HALF  = 64'sd64;
	localparam logic signed [SUM_W-1:0] EFF_MAX_W = 64'sd32767;
	localparam logic signed [15:0]      EFF_POS   = 16'sd32767;
	localparam logic signed [15:0]      EFF_NEG   = -16'sd32767;

	// Step counter of the sequencer.
	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	// Operand sources of the shared multiplier.
	typedef enum logic [2:0] {
		A_ZERO,
		A_ERR,
		A_DIFF,
		A_IH,
		A_IL,
		A_DH,
		A_KD
	} a_sel_t;

	typedef enum logic [2:0] {
		B_ZERO,
		B_SP,
		B_LR,
		B_KP,
		B_KI,
		B_KD,
		B_DL
	} b_sel_t;

	// What the datapath does with last cycle's product.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_INT_ADD,
		OP_CLAMP_DERIV,
		OP_SUM_LOAD,
		OP_SUM_ADD,
		OP_SUM_ADD_SHR,
		OP_HI_LOAD,
		OP_SUM_ADD_HI
	} op_t;

	// Sequencing condition of a step.
	typedef enum logic [1:0] {
		COND_NEXT,
		COND_IN,
		COND_OUT
	} cond_t;

	typedef struct packed {
		a_sel_t a_sel;
		b_sel_t b_sel;
		op_t    op;
		cond_t  cond;
		step_t  target;
	} ucode_t;

	// Control handed from the sequencer to the datapath.
	typedef struct packed {
		logic   load;
		a_sel_t a_sel;
		b_sel_t b_sel;
		op_t    op;
	} dp_ctrl_t;

	// Program: each step issues one multiply and consumes the product of the step before.
	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		case (step)
			4'd0: w = '{A_ZERO, B_ZERO, OP_NONE,        COND_IN,   4'd0};
			4'd1: w = '{A_ERR,  B_SP,   OP_NONE,        COND_NEXT, 4'd0};
			4'd2: w = '{A_DIFF, B_LR,   OP_INT_ADD,     COND_NEXT, 4'd0};
			4'd3: w = '{A_ERR,  B_KP,   OP_CLAMP_DERIV, COND_NEXT, 4'd0};
			4'd4: w = '{A_IH,   B_KI,   OP_SUM_LOAD,    COND_NEXT, 4'd0};
			4'd5: w = '{A_IL,   B_KI,   OP_SUM_ADD,     COND_NEXT, 4'd0};
			4'd6: w = '{A_DH,   B_KD,   OP_SUM_ADD_SHR, COND_NEXT, 4'd0};
			4'd7: w = '{A_KD,   B_DL,   OP_HI_LOAD,     COND_NEXT, 4'd0};
			4'd8: w = '{A_ZERO, B_ZERO, OP_SUM_ADD_HI,  COND_NEXT, 4'd0};
			4'd9: w = '{A_ZERO, B_ZERO, OP_NONE,        COND_OUT,  4'd0};
			default: w = '{A_ZERO, B_ZERO, OP_NONE,     COND_OUT,  4'd0};
		endcase
		return w;
	endfunction

endpackage

/* src/pid_with_integral_clamp_top.sv */
// Top level of the PID controller with anti-windup clamp on the integral.
//
// Each input beat on s_* carries a target and a measured angle; each one yields exactly
// one output beat on m_* with the Q1.15 effort in m_tdata and the saturation flag in
// m_tuser. Gains, integral limit, step period and loop rate are written through the
// cfg_* channel, one register per beat, and are taken in any cycle (cfg_ready is high).
// A microcode program of ten steps runs every update through one shared multiplier:
// the input beat is taken in the idle step, seven multiplies follow, and the last step
// loads the output register. A new input beat is taken no earlier than the cycle after
// the output register is loaded, so the block finishes one update before it takes the
// next; the multiplier sequence sets the sustained rate.
// The output register holds its beat while m_tready is low; the block finishes its
// next item and then waits in its last step until the register is free.
// Reset clears the integral, the previous error and the output valid, and restores the
// register defaults (gains and limit zero, step period 167772, loop rate 100).
module pid_with_integral_clamp_top
	import pidc_pkg::*;
#(
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// Fields from bit 0: target_angle, measured_angle, zero padding.
	input  logic [((2*ANGLE_WIDTH+7)/8)*8-1:0]    s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// Fields from bit 0: effort.
	output logic [15:0]                           m_tdata,
	// Fields from bit 0: effort_saturated.
	output logic                                  m_tuser,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]                  cfg_index,
	input  logic [CFG_DATA_W-1:0]                 cfg_data
);

	logic signed [23:0] prop_gain_q;
	logic signed [23:0] integ_gain_q;
	logic signed [23:0] deriv_gain_q;
	logic [46:0]        integral_limit_q;
	logic [23:0]        step_period_q;
	logic [15:0]        loop_rate_q;

	step_t              step_q;
	step_t              step_n;
	ucode_t             uword;
	dp_ctrl_t           ctrl;
	logic               in_fire;
	logic               out_fire;
	logic               out_valid_q;
	logic [15:0]        effort_q;
	logic               sat_q;
	logic signed [15:0] res_effort;
	logic               res_sat;

	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q      <= '0;
			integ_gain_q     <= '0;
			deriv_gain_q     <= '0;
			integral_limit_q <= '0;
			step_period_q    <= STEP_PERIOD_RST;
			loop_rate_q      <= LOOP_RATE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PROP_GAIN:      prop_gain_q      <= cfg_data[23:0];
				REG_INTEG_GAIN:     integ_gain_q     <= cfg_data[23:0];
				REG_DERIV_GAIN:     deriv_gain_q     <= cfg_data[23:0];
				REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data[46:0];
				REG_STEP_PERIOD:    step_period_q    <= cfg_data[23:0];
				REG_LOOP_RATE:      loop_rate_q      <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer: fetch the control word and work out the next step.
	always_comb begin
		uword    = ucode_rom(step_q);
		s_tready = 1'b0;
		in_fire  = 1'b0;
		out_fire = 1'b0;
		case (uword.cond)
			COND_IN: begin
				s_tready = 1'b1;
				in_fire  = s_tvalid;
				step_n   = s_tvalid ? step_q + step_t'(1) : step_q;
			end
			COND_OUT: begin
				out_fire = !out_valid_q || m_tready;
				step_n   = out_fire ? uword.target : step_q;
			end
			default: begin
				step_n = step_q + step_t'(1);
			end
		endcase
		ctrl.load  = in_fire;
		ctrl.a_sel = uword.a_sel;
		ctrl.b_sel = uword.b_sel;
		ctrl.op    = uword.op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			step_q <= step_n;
		end
	end

	pidc_datapath #(
		.ANGLE_WIDTH(ANGLE_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.tgt           (s_tdata[ANGLE_WIDTH-1:0]),
		.meas          (s_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH]),
		.prop_gain     (prop_gain_q),
		.integ_gain    (integ_gain_q),
		.deriv_gain    (deriv_gain_q),
		.integral_limit(integral_limit_q),
		.step_period   (step_period_q),
		.loop_rate     (loop_rate_q),
		.res_effort    (res_effort),
		.res_sat       (res_sat)
	);

	// Output register: loaded by the last step, cleared when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire) begin
			effort_q <= res_effort;
			sat_q    <= res_sat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = effort_q;
	assign m_tuser  = sat_q;

endmodule

/* src/pidc_mul.sv */
// Shared signed multiplier with a registered product.
module pidc_mul #(
	parameter int A_W = 25,
	parameter int B_W = 27
) (
	input  logic                     clk,
	input  logic signed [A_W-1:0]    a,
	input  logic signed [B_W-1:0]    b,
	output logic signed [A_W+B_W-1:0] prod_q
);

	// One product per cycle, available the cycle after the operands.
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

/* src/pidc_datapath.sv */
// Datapath of the PID controller: error capture, integral, derivative and effort accumulator.
module pidc_datapath
	import pidc_pkg::*;
#(
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dp_ctrl_t                      ctrl,
	input  logic signed [ANGLE_WIDTH-1:0] tgt,
	input  logic signed [ANGLE_WIDTH-1:0] meas,
	input  logic signed [23:0]            prop_gain,
	input  logic signed [23:0]            integ_gain,
	input  logic signed [23:0]            deriv_gain,
	input  logic [46:0]                   integral_limit,
	input  logic [23:0]                   step_period,
	input  logic [15:0]                   loop_rate,
	output logic signed [15:0]            res_effort,
	output logic                          res_sat
);

	localparam int ERR_W   = ANGLE_WIDTH + 1;
	localparam int DIFF_W  = ANGLE_WIDTH + 2;
	localparam int DERIV_W = ANGLE_WIDTH + 19;
	localparam int HI_W    = ANGLE_WIDTH + 17;
	localparam int MA_W    = (ANGLE_WIDTH + 2 > 25) ? ANGLE_WIDTH + 2 : 25;
	localparam int P_W     = MA_W + MB_W;
	localparam int IW_W    = ((ANGLE_WIDTH + 26 > INT_W) ? ANGLE_WIDTH + 26 : INT_W) + 1;

	logic signed [ERR_W-1:0]   err_n;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [ERR_W-1:0]   prev_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic signed [INT_W-1:0]   integ_q;
	logic signed [IW_W-1:0]    iw_q;
	logic signed [IW_W-1:0]    lim_w;
	logic signed [DERIV_W-1:0] deriv_q;
	logic signed [HI_W-1:0]    hi_q;
	logic                      hi_sat_q;
	logic                      hi_neg_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [SUM_W-1:0]   prod_w;
	logic signed [SUM_W-1:0]   rnd;
	logic signed [MA_W-1:0]    op_a;
	logic signed [MB_W-1:0]    op_b;
	logic signed [P_W-1:0]     prod_q;

	assign err_n  = ERR_W'(tgt) - ERR_W'(meas);
	assign lim_w  = IW_W'($signed({1'b0, integral_limit}));
	assign prod_w = SUM_W'(prod_q);

	// Operand selection for the shared multiplier.
	always_comb begin
		case (ctrl.a_sel)
			A_ERR:   op_a = MA_W'(err_q);
			A_DIFF:  op_a = MA_W'(diff_q);
			A_IH:    op_a = MA_W'($signed(integ_q[INT_W-1:INT_LO]));
			A_IL:    op_a = MA_W'($signed({1'b0, integ_q[INT_LO-1:0]}));
			A_DH:    op_a = MA_W'($signed(deriv_q[DERIV_W-1:DL_W]));
			A_KD:    op_a = MA_W'(deriv_gain);
			default: op_a = '0;
		endcase
		case (ctrl.b_sel)
			B_SP:    op_b = MB_W'($signed({1'b0, step_period}));
			B_LR:    op_b = MB_W'($signed({1'b0, loop_rate}));
			B_KP:    op_b = MB_W'(prop_gain);
			B_KI:    op_b = MB_W'(integ_gain);
			B_KD:    op_b = MB_W'(deriv_gain);
			B_DL:    op_b = MB_W'($signed({1'b0, deriv_q[DL_W-1:0]}));
			default: op_b = '0;
		endcase
	end

	pidc_mul #(
		.A_W(MA_W),
		.B_W(MB_W)
	) u_mul (
		.clk   (clk),
		.a     (op_a),
		.b     (op_b),
		.prod_q(prod_q)
	);

	// Loop state: previous error and the clamped integral.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			integ_q <= '0;
		end else begin
			if (ctrl.load) begin
				prev_q <= err_n;
			end
			if (ctrl.op == OP_CLAMP_DERIV) begin
				if (iw_q > lim_w) begin
					integ_q <= INT_W'(lim_w);
				end else if (iw_q < -lim_w) begin
					integ_q <= INT_W'(-lim_w);
				end else begin
					integ_q <= INT_W'(iw_q);
				end
			end
		end
	end

	// Working registers, driven by the control word of each step.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			err_q  <= err_n;
			diff_q <= DIFF_W'(err_n) - DIFF_W'(prev_q);
		end
		case (ctrl.op)
			OP_INT_ADD: begin
				iw_q <= IW_W'(integ_q) + IW_W'(prod_q);
			end
			OP_CLAMP_DERIV: begin
				deriv_q <= DERIV_W'(prod_q);
			end
			OP_SUM_LOAD: begin
				sum_q <= prod_w;
			end
			OP_SUM_ADD: begin
				sum_q <= sum_q + prod_w;
			end
			OP_SUM_ADD_SHR: begin
				sum_q <= sum_q + (prod_w >>> INT_LO);
			end
			OP_HI_LOAD: begin
				hi_q     <= HI_W'(prod_q);
				hi_sat_q <= (prod_w >= HI_SAT) || (prod_w <= -HI_SAT);
				hi_neg_q <= prod_w[SUM_W-1];
			end
			OP_SUM_ADD_HI: begin
				sum_q <= sum_q + prod_w + (SUM_W'(hi_q) <<< DL_W);
			end
			default: begin
			end
		endcase
	end

	// Saturation and rounding of the finished sum to Q1.15.
	always_comb begin
		rnd = (sum_q + RND_HALF) >>> 7;
		if (hi_sat_q) begin
			res_sat    = 1'b1;
			res_effort = hi_neg_q ? EFF_NEG : EFF_POS;
		end else if (sum_q > SUM_SAT) begin
			res_sat    = 1'b1;
			res_effort = EFF_POS;
		end else if (sum_q < -SUM_SAT) begin
			res_sat    = 1'b1;
			res_effort = EFF_NEG;
		end else begin
			res_sat = 1'b0;
			if (rnd > EFF_MAX_W) begin
				res_effort = EFF_POS;
			end else if (rnd < -EFF_MAX_W) begin
				res_effort = EFF_NEG;
			end else begin
				res_effort = rnd[15:0];
			end
		end
	end

endmodule

/* src/pidc_checker.sv */
// Port-level checker for the PID controller, bound to the top level.
module pidc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser
);

	// A stalled output beat stays valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	// A stalled output beat keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("output payload changed while stalled");

	// One update at a time: no input beat in the cycle after one was taken.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an update is running");

	// The effort never reaches minus one.
	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata != 16'h8000)
		else $error("effort outside the symmetric range");

	// A saturated beat carries full-scale effort.
	a_sat_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata == 16'h7FFF) || (m_tdata == 16'h8001))
		else $error("saturated beat without full-scale effort");

endmodule

bind pid_with_integral_clamp_top pidc_checker u_pidc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
